### rtl/assert_macros.svh
// assertion macros used by the rtl file that carries checks
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/mtg_pkg.sv
// shared constants, types and functions of the mt19937 generator
// no dependencies; imported by every module of the block
package mtg_pkg;

  localparam int StateWords   = 624;
  localparam int MiddleOffset = 397;
  localparam int PosW         = $clog2(StateWords);
  localparam int QueueDepth   = 4;

  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] InitMult    = 32'd1812433253;
  localparam logic [31:0] UpperMask   = 32'h8000_0000;
  localparam logic [31:0] LowerMask   = 32'h7fff_ffff;
  localparam logic [31:0] TwistXor    = 32'd2567483615;
  localparam logic [31:0] TemperB     = 32'd2636928640;
  localparam logic [31:0] TemperC     = 32'd4022730752;

  // one state word written by the seeding sweep
  typedef struct packed {
    logic            active;
    logic [PosW-1:0] addr;
    logic [31:0]     data;
  } mtg_fill_t;

  // twist of one word from its own upper bit, its successor and the middle word
  function automatic logic [31:0] mtg_twist(input logic [31:0] cur,
                                            input logic [31:0] nxt,
                                            input logic [31:0] mid);
    logic [31:0] y;
    logic [31:0] w;
    y = (cur & UpperMask) | (nxt & LowerMask);
    w = mid ^ (y >> 1);
    if (y[0]) begin
      w = w ^ TwistXor;
    end
    return w;
  endfunction

  // output tempering
  function automatic logic [31:0] mtg_temper(input logic [31:0] x);
    logic [31:0] w;
    w = x ^ (x >> 11);
    w = w ^ ((w << 7) & TemperB);
    w = w ^ ((w << 15) & TemperC);
    w = w ^ (w >> 18);
    return w;
  endfunction

endpackage

### rtl/mersenne_twister_generator_core.sv
// top level of the mt19937 generator: seeder, front queue and twist back end
// depends on mtg_pkg, mtg_seeder, mtg_front, mtg_back, assert_macros.svh
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o   | draw_request_i [0:0]
//   out     | output    | out_valid_o / out_stall_i | random_word_o [31:0]
//   seed    | input     | seed_word_we_i            | seed_word_i [31:0]
//
// one word per cycle sustained while out_stall_i is low; a draw passes through
// the draw queue count, the registered state-memory read and the output buffer
// on its way to the output. after reset and after each seed write the state
// memory is filled one word a cycle, all 624 words, with in_stall_o high
// throughout.
// an empty request beat is taken and gives no result; out_stall_i holds
// results in a two-entry buffer, then backs up the draw queue.
`include "assert_macros.svh"

module mersenne_twister_generator_core #(
  parameter int QDepth = mtg_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_word_we_i,
  input  logic [31:0] seed_word_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        draw_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);
  import mtg_pkg::*;

  mtg_fill_t fill;
  logic      pending;
  logic      issue;

  // state memory seeding
  mtg_seeder u_seeder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_word_we_i (seed_word_we_i),
    .seed_word_i    (seed_word_i),
    .fill_o         (fill)
  );

  // request intake and draw queue
  mtg_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .draw_request_i (draw_request_i),
    .seeding_i      (fill.active),
    .issue_i        (issue),
    .pending_o      (pending)
  );

  // twist, temper and deliver
  mtg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fill_i        (fill),
    .pending_i     (pending),
    .issue_o       (issue),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  // checks
  `MTG_ASSERT_NOW(a_stall_while_seeding, clk_i, rst_ni, fill.active, in_stall_o)
  `MTG_ASSERT_NOW(a_no_issue_while_seeding, clk_i, rst_ni, fill.active, !issue)
  `MTG_ASSERT_NOW(a_issue_needs_pending, clk_i, rst_ni, issue, pending)
  `MTG_ASSERT_NEXT(a_seed_write_starts_fill, clk_i, rst_ni, seed_word_we_i, fill.active)

endmodule

### rtl/mtg_seeder.sv
// seeding sweep: fills the state memory by the init recurrence, one word a cycle
// depends on mtg_pkg
module mtg_seeder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_word_we_i,
  input  logic [31:0]       seed_word_i,
  output mtg_pkg::mtg_fill_t fill_o
);
  import mtg_pkg::*;

  localparam logic [PosW-1:0] LastIdx = PosW'(StateWords - 1);

  logic            busy_q, busy_d;
  logic [PosW-1:0] idx_q, idx_d;
  logic [31:0]     word_q, word_d;
  logic [31:0]     mix;
  logic [31:0]     prod;

  // next word of the recurrence
  always_comb begin
    mix  = word_q ^ (word_q >> 30);
    prod = InitMult * mix;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    word_d = word_q;
    if (seed_word_we_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      word_d = seed_word_i;
    end else if (busy_q) begin
      idx_d  = idx_q + 1'b1;
      word_d = prod + 32'(idx_q) + 32'd1;
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
  end

  // sweep starts again from the default seed on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      word_q <= DefaultSeed;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      word_q <= word_d;
    end
  end

  assign fill_o.active = busy_q;
  assign fill_o.addr   = idx_q;
  assign fill_o.data   = word_q;

endmodule

### rtl/mtg_front.sv
// front end: accepts input beats, drops empty requests, queues pending draws
// depends on mtg_pkg
module mtg_front #(
  parameter int QDepth = mtg_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic draw_request_i,
  input  logic seeding_i,
  input  logic issue_i,
  output logic pending_o
);
  import mtg_pkg::*;

  localparam int CntW = $clog2(QDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;

  // stall while seeding or while the queue is full
  assign in_stall_o = seeding_i || (cnt_q == CntW'(QDepth));
  assign push       = in_valid_i && !in_stall_o && draw_request_i;
  assign pending_o  = (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !issue_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && issue_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/mtg_back.sv
// back end: state memory, on-the-fly twist, tempering and output buffer
// depends on mtg_pkg
module mtg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtg_pkg::mtg_fill_t fill_i,
  input  logic               pending_i,
  output logic               issue_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        random_word_o
);
  import mtg_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(StateWords - 1);

  logic [31:0]     mem_q [StateWords];
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] nxt_addr;
  logic [PosW-1:0] mid_addr;
  logic [PosW:0]   mid_sum;
  logic [31:0]     rd_nxt_q;
  logic [31:0]     rd_mid_q;
  logic [31:0]     cur_q;
  logic            s1_v_q;
  logic [PosW-1:0] s1_pos_q;
  logic [31:0]     twisted;
  logic [31:0]     tempered;
  logic [31:0]     ob_q [2];
  logic            ob_wr_q;
  logic            ob_rd_q;
  logic [1:0]      ob_cnt_q, ob_cnt_d;
  logic            out_pop;
  logic [2:0]      occ;

  // successor and middle addresses, modulo the state size
  always_comb begin
    nxt_addr = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    mid_sum  = {1'b0, pos_q} + (PosW + 1)'(MiddleOffset);
    if (mid_sum >= (PosW + 1)'(StateWords)) begin
      mid_addr = PosW'(mid_sum - (PosW + 1)'(StateWords));
    end else begin
      mid_addr = PosW'(mid_sum);
    end
  end

  // issue only with room for the result in the output buffer
  assign out_pop = out_valid_o && !out_stall_i;
  assign occ     = {1'b0, ob_cnt_q} + {2'b0, s1_v_q} - {2'b0, out_pop};
  assign issue_o = pending_i && !fill_i.active && (occ < 3'd2);

  always_comb begin
    pos_d = pos_q;
    if (fill_i.active) begin
      pos_d = '0;
    end else if (issue_o) begin
      pos_d = nxt_addr;
    end
  end

  // state memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (fill_i.active) begin
      mem_q[fill_i.addr] <= fill_i.data;
    end else if (s1_v_q) begin
      mem_q[s1_pos_q] <= twisted;
    end
    if (issue_o) begin
      rd_nxt_q <= mem_q[nxt_addr];
      rd_mid_q <= mem_q[mid_addr];
      s1_pos_q <= pos_q;
    end
  end

  // twist and temper in the stage after the memory read
  assign twisted  = mtg_twist(cur_q, rd_nxt_q, rd_mid_q);
  assign tempered = mtg_temper(twisted);

  // untwisted word at the current position, carried from the previous read
  always_ff @(posedge clk_i) begin
    if (fill_i.active && (fill_i.addr == '0)) begin
      cur_q <= fill_i.data;
    end else if (s1_v_q) begin
      cur_q <= rd_nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      s1_v_q <= issue_o;
    end
  end

  // two-entry output buffer
  always_comb begin
    ob_cnt_d = ob_cnt_q;
    if (s1_v_q && !out_pop) begin
      ob_cnt_d = ob_cnt_q + 1'b1;
    end else if (!s1_v_q && out_pop) begin
      ob_cnt_d = ob_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      ob_q[ob_wr_q] <= tempered;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      ob_cnt_q <= ob_cnt_d;
      if (s1_v_q) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (out_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
    end
  end

  assign out_valid_o   = (ob_cnt_q != '0);
  assign random_word_o = ob_q[ob_rd_q];

endmodule
